// ----- design/source_char_lexer_defines.svh -----
// Assertion macros shared by the lexer modules.
`ifndef SOURCE_CHAR_LEXER_DEFINES_SVH
`define SOURCE_CHAR_LEXER_DEFINES_SVH

`ifndef SYNTH
// Checked while out of reset.
`define SCL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every edge, reset included.
`define SCL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define SCL_ASSERT(lbl, prop, msg)
`define SCL_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- design/scl_pkg.sv -----
// Types, codes and helpers shared by the source character lexer.
package scl_pkg;

    localparam int MAX_SOURCE_BYTES = 65536;
    localparam int POS_CAP_INT = (MAX_SOURCE_BYTES - 1 < 65535) ? MAX_SOURCE_BYTES - 1 : 65535;
    localparam logic [15:0] POS_CAP = 16'(POS_CAP_INT);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);

    // Token kinds.
    localparam logic [4:0] KIND_LPAREN       = 5'd0;
    localparam logic [4:0] KIND_RPAREN       = 5'd1;
    localparam logic [4:0] KIND_LBRACE       = 5'd2;
    localparam logic [4:0] KIND_RBRACE       = 5'd3;
    localparam logic [4:0] KIND_SEMI         = 5'd4;
    localparam logic [4:0] KIND_COMMA        = 5'd5;
    localparam logic [4:0] KIND_DOT          = 5'd6;
    localparam logic [4:0] KIND_MINUS        = 5'd7;
    localparam logic [4:0] KIND_PLUS         = 5'd8;
    localparam logic [4:0] KIND_SLASH        = 5'd9;
    localparam logic [4:0] KIND_STAR         = 5'd10;
    localparam logic [4:0] KIND_BANG         = 5'd11;
    localparam logic [4:0] KIND_EQUAL        = 5'd13;
    localparam logic [4:0] KIND_GREATER      = 5'd15;
    localparam logic [4:0] KIND_LESS         = 5'd17;
    localparam logic [4:0] KIND_NUMBER       = 5'd19;
    localparam logic [4:0] KIND_STRING       = 5'd20;
    localparam logic [4:0] KIND_EOF          = 5'd21;
    localparam logic [4:0] KIND_UNEXPECTED   = 5'd22;
    localparam logic [4:0] KIND_UNTERMINATED = 5'd23;

    // Character codes.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'd0,
        MODE_SLASH    = 4'd1,
        MODE_COMMENT  = 4'd2,
        MODE_BANG     = 4'd3,
        MODE_EQUAL    = 4'd4,
        MODE_LESS     = 4'd5,
        MODE_GREATER  = 4'd6,
        MODE_NUM_INT  = 4'd7,
        MODE_NUM_DOT  = 4'd8,
        MODE_NUM_FRAC = 4'd9,
        MODE_STRING   = 4'd10
    } mode_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
    } tok_t;

    // All results caused by one input byte; they share one line number.
    typedef struct packed {
        logic [1:0]  cnt;
        tok_t [2:0]  tok;
        logic [15:0] line;
    } grp_t;

    typedef struct packed {
        logic nonempty;
        logic full;
    } q_stat_t;

    function automatic logic [15:0] sat_sub(input logic [16:0] a, input logic [16:0] b);
        logic [16:0] diff;
        diff = a - b;
        return (a > b) ? diff[15:0] : 16'd0;
    endfunction

    // Single-character kind of a held operator.
    function automatic logic [4:0] pending_single(input mode_t m);
        case (m)
            MODE_BANG:  return KIND_BANG;
            MODE_EQUAL: return KIND_EQUAL;
            MODE_LESS:  return KIND_LESS;
            default:    return KIND_GREATER;
        endcase
    endfunction

endpackage

// ----- design/source_char_lexer.sv -----
// Top level of the streaming source character lexer.
// Throughput: one source byte per cycle unless the queue is full; a byte's tokens leave in turn.
// A byte's tokens enter the queue when it is accepted, then load into the output register.
// The four-group queue between scanner and output stage sets how long input may run ahead.
// Reset: synchronous, active low; clears scan mode, offsets, queue and output; sets the line count to one.
module source_char_lexer (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_code
    input  logic        s_tlast,    // is_end: end of source, no character
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [4:0] token_kind, [20:5] start_offset,
                                    // [36:21] token_length, [52:37] line_number, rest zero
    output logic        m_tlast     // last_of_run: final token caused by one request
);

    // The scanner works at the byte rate and drops each byte's tokens into the
    // queue as one group; the output stage splits the groups back into tokens.
    // Input stalls only when the queue is full.
    scl_pkg::q_stat_t q_stat;
    scl_pkg::grp_t    push_data, pop_data;
    logic             push, pop;
    scl_pkg::tok_t    out_tok;
    logic [15:0]      out_line;

    scl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .char_code (s_tdata),
        .is_end    (s_tlast),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    scl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    scl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok),
        .out_line  (out_line),
        .out_last  (m_tlast)
    );

    // Pack the token fields from the lowest bit up, padded to whole bytes.
    assign m_tdata = {3'b000, out_line, out_tok.len, out_tok.start, out_tok.kind};

endmodule

// ----- design/scl_front.sv -----
// Scanner front end: takes one byte per request and forms its token group.
module scl_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     char_code,
    input  logic           is_end,
    input  scl_pkg::q_stat_t q_stat,
    output logic           push,
    output scl_pkg::grp_t  push_data
);

    scl_pkg::mode_t mode_reg, mode_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] tb_reg, tb_next;

    logic        accept;
    logic [15:0] dotpos;
    logic [15:0] len_p, len_dot, len_str;
    logic        again, bump;
    logic [2:0]  ev;
    scl_pkg::tok_t [2:0] et;
    logic [1:0]  n;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    assign dotpos  = (pos_reg != 16'd0) ? pos_reg - 16'd1 : 16'd0;
    assign len_p   = scl_pkg::sat_sub({1'b0, pos_reg}, {1'b0, tb_reg});
    assign len_dot = scl_pkg::sat_sub({1'b0, dotpos}, {1'b0, tb_reg});
    assign len_str = scl_pkg::sat_sub({1'b0, pos_reg} + 17'd1, {1'b0, tb_reg});

    always_comb begin
        mode_next = mode_reg;
        tb_next   = tb_reg;
        pos_next  = (pos_reg < scl_pkg::POS_CAP) ? pos_reg + 16'd1 : pos_reg;
        again     = 1'b0;
        bump      = 1'b0;
        ev        = '0;
        et        = '0;

        if (is_end) begin
            // Flush whatever is held, then EOF and back to the reset state.
            case (mode_reg)
                scl_pkg::MODE_SLASH: begin
                    ev[0] = 1'b1;
                    et[0] = '{scl_pkg::KIND_SLASH, tb_reg, 16'd1};
                end
                scl_pkg::MODE_BANG, scl_pkg::MODE_EQUAL,
                scl_pkg::MODE_LESS, scl_pkg::MODE_GREATER: begin
                    ev[0] = 1'b1;
                    et[0] = '{scl_pkg::pending_single(mode_reg), tb_reg, 16'd1};
                end
                scl_pkg::MODE_NUM_INT, scl_pkg::MODE_NUM_FRAC: begin
                    ev[0] = 1'b1;
                    et[0] = '{scl_pkg::KIND_NUMBER, tb_reg, len_p};
                end
                scl_pkg::MODE_NUM_DOT: begin
                    ev[0] = 1'b1;
                    et[0] = '{scl_pkg::KIND_NUMBER, tb_reg, len_dot};
                    ev[1] = 1'b1;
                    et[1] = '{scl_pkg::KIND_DOT, dotpos, 16'd1};
                end
                scl_pkg::MODE_STRING: begin
                    ev[0] = 1'b1;
                    et[0] = '{scl_pkg::KIND_UNTERMINATED, tb_reg, len_p};
                end
                default: begin
                end
            endcase
            ev[2]     = 1'b1;
            et[2]     = '{scl_pkg::KIND_EOF, pos_reg, 16'd0};
            mode_next = scl_pkg::MODE_IDLE;
            tb_next   = 16'd0;
            pos_next  = 16'd0;
        end else begin
            case (mode_reg)
                scl_pkg::MODE_SLASH: begin
                    if (char_code == scl_pkg::CH_SLASH) begin
                        mode_next = scl_pkg::MODE_COMMENT;
                    end else begin
                        ev[0] = 1'b1;
                        et[0] = '{scl_pkg::KIND_SLASH, tb_reg, 16'd1};
                        again = 1'b1;
                    end
                end
                scl_pkg::MODE_COMMENT: begin
                    if (char_code == scl_pkg::CH_LF) begin
                        bump      = 1'b1;
                        mode_next = scl_pkg::MODE_IDLE;
                    end
                end
                scl_pkg::MODE_BANG, scl_pkg::MODE_EQUAL,
                scl_pkg::MODE_LESS, scl_pkg::MODE_GREATER: begin
                    ev[0] = 1'b1;
                    if (char_code == scl_pkg::CH_EQ) begin
                        et[0] = '{scl_pkg::pending_single(mode_reg) + 5'd1, tb_reg, 16'd2};
                        mode_next = scl_pkg::MODE_IDLE;
                    end else begin
                        et[0] = '{scl_pkg::pending_single(mode_reg), tb_reg, 16'd1};
                        again = 1'b1;
                    end
                end
                scl_pkg::MODE_NUM_INT: begin
                    if (char_code inside {[scl_pkg::CH_0:scl_pkg::CH_9]}) begin
                        mode_next = scl_pkg::MODE_NUM_INT;
                    end else if (char_code == scl_pkg::CH_DOT) begin
                        mode_next = scl_pkg::MODE_NUM_DOT;
                    end else begin
                        ev[0] = 1'b1;
                        et[0] = '{scl_pkg::KIND_NUMBER, tb_reg, len_p};
                        again = 1'b1;
                    end
                end
                scl_pkg::MODE_NUM_DOT: begin
                    if (char_code inside {[scl_pkg::CH_0:scl_pkg::CH_9]}) begin
                        mode_next = scl_pkg::MODE_NUM_FRAC;
                    end else begin
                        // The dot did not open a fraction: it is a token of its own.
                        ev[0] = 1'b1;
                        et[0] = '{scl_pkg::KIND_NUMBER, tb_reg, len_dot};
                        ev[1] = 1'b1;
                        et[1] = '{scl_pkg::KIND_DOT, dotpos, 16'd1};
                        again = 1'b1;
                    end
                end
                scl_pkg::MODE_NUM_FRAC: begin
                    if (!(char_code inside {[scl_pkg::CH_0:scl_pkg::CH_9]})) begin
                        ev[0] = 1'b1;
                        et[0] = '{scl_pkg::KIND_NUMBER, tb_reg, len_p};
                        again = 1'b1;
                    end
                end
                scl_pkg::MODE_STRING: begin
                    if (char_code == scl_pkg::CH_QUOTE) begin
                        ev[0] = 1'b1;
                        et[0] = '{scl_pkg::KIND_STRING, tb_reg, len_str};
                        mode_next = scl_pkg::MODE_IDLE;
                    end else if (char_code == scl_pkg::CH_LF) begin
                        bump = 1'b1;
                    end
                end
                default: begin
                    again = 1'b1;
                end
            endcase

            // The byte starts something new.
            if (again) begin
                mode_next = scl_pkg::MODE_IDLE;
                case (char_code)
                    scl_pkg::CH_SPACE, scl_pkg::CH_CR, scl_pkg::CH_TAB: begin
                    end
                    scl_pkg::CH_LF: begin
                        bump = 1'b1;
                    end
                    scl_pkg::CH_LPAREN: begin
                        ev[2] = 1'b1;
                        et[2] = '{scl_pkg::KIND_LPAREN, pos_reg, 16'd1};
                    end
                    scl_pkg::CH_RPAREN: begin
                        ev[2] = 1'b1;
                        et[2] = '{scl_pkg::KIND_RPAREN, pos_reg, 16'd1};
                    end
                    scl_pkg::CH_LBRACE: begin
                        ev[2] = 1'b1;
                        et[2] = '{scl_pkg::KIND_LBRACE, pos_reg, 16'd1};
                    end
                    scl_pkg::CH_RBRACE: begin
                        ev[2] = 1'b1;
                        et[2] = '{scl_pkg::KIND_RBRACE, pos_reg, 16'd1};
                    end
                    scl_pkg::CH_SEMI: begin
                        ev[2] = 1'b1;
                        et[2] = '{scl_pkg::KIND_SEMI, pos_reg, 16'd1};
                    end
                    scl_pkg::CH_COMMA: begin
                        ev[2] = 1'b1;
                        et[2] = '{scl_pkg::KIND_COMMA, pos_reg, 16'd1};
                    end
                    scl_pkg::CH_DOT: begin
                        ev[2] = 1'b1;
                        et[2] = '{scl_pkg::KIND_DOT, pos_reg, 16'd1};
                    end
                    scl_pkg::CH_MINUS: begin
                        ev[2] = 1'b1;
                        et[2] = '{scl_pkg::KIND_MINUS, pos_reg, 16'd1};
                    end
                    scl_pkg::CH_PLUS: begin
                        ev[2] = 1'b1;
                        et[2] = '{scl_pkg::KIND_PLUS, pos_reg, 16'd1};
                    end
                    scl_pkg::CH_STAR: begin
                        ev[2] = 1'b1;
                        et[2] = '{scl_pkg::KIND_STAR, pos_reg, 16'd1};
                    end
                    scl_pkg::CH_SLASH: begin
                        mode_next = scl_pkg::MODE_SLASH;
                        tb_next   = pos_reg;
                    end
                    scl_pkg::CH_BANG: begin
                        mode_next = scl_pkg::MODE_BANG;
                        tb_next   = pos_reg;
                    end
                    scl_pkg::CH_EQ: begin
                        mode_next = scl_pkg::MODE_EQUAL;
                        tb_next   = pos_reg;
                    end
                    scl_pkg::CH_LT: begin
                        mode_next = scl_pkg::MODE_LESS;
                        tb_next   = pos_reg;
                    end
                    scl_pkg::CH_GT: begin
                        mode_next = scl_pkg::MODE_GREATER;
                        tb_next   = pos_reg;
                    end
                    scl_pkg::CH_QUOTE: begin
                        mode_next = scl_pkg::MODE_STRING;
                        tb_next   = pos_reg;
                    end
                    default: begin
                        if (char_code inside {[scl_pkg::CH_0:scl_pkg::CH_9]}) begin
                            mode_next = scl_pkg::MODE_NUM_INT;
                            tb_next   = pos_reg;
                        end else begin
                            ev[2] = 1'b1;
                            et[2] = '{scl_pkg::KIND_UNEXPECTED, pos_reg, 16'd1};
                        end
                    end
                endcase
            end
        end

        if (is_end) begin
            line_next = 16'd1;
        end else if (bump && line_reg != 16'hFFFF) begin
            line_next = line_reg + 16'd1;
        end else begin
            line_next = line_reg;
        end
    end

    // Pack the emitted tokens into consecutive slots, in emission order.
    always_comb begin
        n         = 2'd0;
        push_data = '0;
        for (int i = 0; i < 3; i++) begin
            if (ev[i]) begin
                push_data.tok[n] = et[i];
                n = n + 2'd1;
            end
        end
        push_data.cnt  = n;
        push_data.line = line_reg;
    end

    assign push = accept && (ev != 3'b000);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= scl_pkg::MODE_IDLE;
            pos_reg  <= 16'd0;
            line_reg <= 16'd1;
            tb_reg   <= 16'd0;
        end else if (accept) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            line_reg <= line_next;
            tb_reg   <= tb_next;
        end
    end

endmodule

// ----- design/scl_queue.sv -----
// Short queue of token groups between the scanner and the output stage.
`include "source_char_lexer_defines.svh"

module scl_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  scl_pkg::grp_t    push_data,
    input  logic             pop,
    output scl_pkg::grp_t    pop_data,
    output scl_pkg::q_stat_t stat
);

    scl_pkg::grp_t mem_reg [scl_pkg::Q_DEPTH];
    logic [scl_pkg::Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [scl_pkg::Q_AW:0]   count_reg, count_next;
    logic do_push, do_pop;

    assign stat.full     = (count_reg == (scl_pkg::Q_AW + 1)'(scl_pkg::Q_DEPTH));
    assign stat.nonempty = (count_reg != '0);
    assign do_push       = push && !stat.full;
    assign do_pop        = pop && stat.nonempty;
    assign pop_data      = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `SCL_ASSERT(a_no_push_full, !(push && stat.full), "group pushed into a full queue")
    `SCL_ASSERT(a_count_bound, count_reg <= (scl_pkg::Q_AW + 1)'(scl_pkg::Q_DEPTH), "queue count beyond depth")
    `SCL_ASSERT(a_ptr_track, (wr_ptr_reg - rd_ptr_reg) == count_reg[scl_pkg::Q_AW-1:0], "queue pointers disagree with count")
    `SCL_ASSERT_RST(a_reset_empty, !aresetn |=> count_reg == '0, "queue not empty after reset")

endmodule

// ----- design/scl_back.sv -----
// Output stage: hands out the tokens of each queued group one per cycle while out_ready is high.
`include "source_char_lexer_defines.svh"

module scl_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  scl_pkg::q_stat_t q_stat,
    input  scl_pkg::grp_t    q_data,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output scl_pkg::tok_t    out_tok,
    output logic [15:0]      out_line,
    output logic             out_last
);

    scl_pkg::grp_t cur_reg;
    logic [1:0]    idx_reg;
    logic          valid_reg;
    logic          take, last, load;

    assign last = (idx_reg == cur_reg.cnt - 2'd1);
    assign take = valid_reg && out_ready;
    assign load = q_stat.nonempty && (!valid_reg || (take && last));
    assign pop  = load;

    assign out_valid = valid_reg;
    assign out_tok   = cur_reg.tok[idx_reg];
    assign out_line  = cur_reg.line;
    assign out_last  = last;

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (take) begin
            if (last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    `SCL_ASSERT(a_idx_in_group, valid_reg |-> (idx_reg < cur_reg.cnt), "token index past end of group")

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the streaming source character lexer.
module tb;
    import scl_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 16;
    localparam int RANDOM_ITEMS = 370;
    localparam int REPORT_MAX   = 10;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    // One token as it leaves the result channel.
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } token_rec_t;

    // Directed stimulus row; typed rows carry their single expected token.
    typedef struct packed {
        logic [7:0]  ch;
        logic        eos;
        logic        typed;
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;

    token_rec_t tok_q[$];
    dir_row_t   dir_rows [26];

    int mismatches = 0;
    int checked    = 0;
    int sent       = 0;
    int sources    = 0;
    int cycles     = 0;
    int send_calm  = 0;
    int recv_calm  = 0;

    // Scanner state of the predictor.
    logic [15:0] lx_pos;
    logic [15:0] lx_line;
    logic [15:0] lx_begin;
    mode_t       lx_mode;
    token_rec_t  step_out [3];
    int          step_n;

    source_char_lexer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
    end

    function automatic logic [15:0] sub_floor(input logic [16:0] a, input logic [16:0] b);
        logic [16:0] d;
        d = a - b;
        return (a > b) ? d[15:0] : 16'd0;
    endfunction

    function automatic logic [4:0] held_kind(input mode_t m);
        case (m)
            MODE_BANG:  return KIND_BANG;
            MODE_EQUAL: return KIND_EQUAL;
            MODE_LESS:  return KIND_LESS;
            default:    return KIND_GREATER;
        endcase
    endfunction

    function void lex_reset();
        lx_pos   = 16'd0;
        lx_line  = 16'd1;
        lx_mode  = MODE_IDLE;
        lx_begin = 16'd0;
    endfunction

    function void push_tok(input logic [4:0] k, input logic [15:0] s, input logic [15:0] l);
        if (step_n < 3) begin
            step_out[step_n] = '{k, s, l, lx_line, 1'b0};
            step_n++;
        end
    endfunction

    function void bump_line();
        if (lx_line < 16'hFFFF) lx_line = lx_line + 16'd1;
    endfunction

    // Advances the predicted scanner by one request and leaves its tokens in step_out.
    function void lex_step(input logic [7:0] c, input logic eos);
        logic [15:0] p;
        logic [15:0] dotpos;
        mode_t       m;
        logic        again;
        step_n = 0;
        p      = lx_pos;
        m      = lx_mode;
        dotpos = (p > 16'd0) ? p - 16'd1 : 16'd0;
        again  = 1'b0;
        if (eos) begin
            case (m)
                MODE_SLASH: push_tok(KIND_SLASH, lx_begin, 16'd1);
                MODE_BANG, MODE_EQUAL, MODE_LESS, MODE_GREATER:
                    push_tok(held_kind(m), lx_begin, 16'd1);
                MODE_NUM_INT, MODE_NUM_FRAC:
                    push_tok(KIND_NUMBER, lx_begin, sub_floor({1'b0, p}, {1'b0, lx_begin}));
                MODE_NUM_DOT: begin
                    push_tok(KIND_NUMBER, lx_begin,
                             sub_floor({1'b0, dotpos}, {1'b0, lx_begin}));
                    push_tok(KIND_DOT, dotpos, 16'd1);
                end
                MODE_STRING: push_tok(KIND_UNTERMINATED, lx_begin,
                                      sub_floor({1'b0, p}, {1'b0, lx_begin}));
                default: ;
            endcase
            push_tok(KIND_EOF, p, 16'd0);
            lex_reset();
        end else begin
            case (m)
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        lx_mode = MODE_COMMENT;
                    end else begin
                        push_tok(KIND_SLASH, lx_begin, 16'd1);
                        again = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_LF) begin
                        bump_line();
                        lx_mode = MODE_IDLE;
                    end
                end
                MODE_BANG, MODE_EQUAL, MODE_LESS, MODE_GREATER: begin
                    if (c == CH_EQ) begin
                        push_tok(held_kind(m) + 5'd1, lx_begin, 16'd2);
                        lx_mode = MODE_IDLE;
                    end else begin
                        push_tok(held_kind(m), lx_begin, 16'd1);
                        again = 1'b1;
                    end
                end
                MODE_NUM_INT: begin
                    if (c == CH_DOT) begin
                        lx_mode = MODE_NUM_DOT;
                    end else if (!(c >= CH_0 && c <= CH_9)) begin
                        push_tok(KIND_NUMBER, lx_begin,
                                 sub_floor({1'b0, p}, {1'b0, lx_begin}));
                        again = 1'b1;
                    end
                end
                MODE_NUM_DOT: begin
                    if (c >= CH_0 && c <= CH_9) begin
                        lx_mode = MODE_NUM_FRAC;
                    end else begin
                        // The dot was not a fraction: number ends before it.
                        push_tok(KIND_NUMBER, lx_begin,
                                 sub_floor({1'b0, dotpos}, {1'b0, lx_begin}));
                        push_tok(KIND_DOT, dotpos, 16'd1);
                        again = 1'b1;
                    end
                end
                MODE_NUM_FRAC: begin
                    if (!(c >= CH_0 && c <= CH_9)) begin
                        push_tok(KIND_NUMBER, lx_begin,
                                 sub_floor({1'b0, p}, {1'b0, lx_begin}));
                        again = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        push_tok(KIND_STRING, lx_begin,
                                 sub_floor(17'(p) + 17'd1, {1'b0, lx_begin}));
                        lx_mode = MODE_IDLE;
                    end else if (c == CH_LF) begin
                        bump_line();
                    end
                end
                default: again = 1'b1;
            endcase
            if (again) begin
                lx_mode = MODE_IDLE;
                case (c)
                    CH_SPACE, CH_CR, CH_TAB: ;
                    CH_LF:     bump_line();
                    CH_LPAREN: push_tok(KIND_LPAREN, p, 16'd1);
                    CH_RPAREN: push_tok(KIND_RPAREN, p, 16'd1);
                    CH_LBRACE: push_tok(KIND_LBRACE, p, 16'd1);
                    CH_RBRACE: push_tok(KIND_RBRACE, p, 16'd1);
                    CH_SEMI:   push_tok(KIND_SEMI, p, 16'd1);
                    CH_COMMA:  push_tok(KIND_COMMA, p, 16'd1);
                    CH_DOT:    push_tok(KIND_DOT, p, 16'd1);
                    CH_MINUS:  push_tok(KIND_MINUS, p, 16'd1);
                    CH_PLUS:   push_tok(KIND_PLUS, p, 16'd1);
                    CH_STAR:   push_tok(KIND_STAR, p, 16'd1);
                    CH_SLASH:  begin lx_mode = MODE_SLASH;   lx_begin = p; end
                    CH_BANG:   begin lx_mode = MODE_BANG;    lx_begin = p; end
                    CH_EQ:     begin lx_mode = MODE_EQUAL;   lx_begin = p; end
                    CH_LT:     begin lx_mode = MODE_LESS;    lx_begin = p; end
                    CH_GT:     begin lx_mode = MODE_GREATER; lx_begin = p; end
                    CH_QUOTE:  begin lx_mode = MODE_STRING;  lx_begin = p; end
                    default: begin
                        if (c >= CH_0 && c <= CH_9) begin
                            lx_mode  = MODE_NUM_INT;
                            lx_begin = p;
                        end else begin
                            push_tok(KIND_UNEXPECTED, p, 16'd1);
                        end
                    end
                endcase
            end
            if (lx_pos < POS_CAP) lx_pos = lx_pos + 16'd1;
        end
        if (step_n > 0) step_out[step_n - 1].last = 1'b1;
    endfunction

    // Wait for one request or one result, with calm stretches of no waiting.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) calm = $urandom_range(4, 24);
        return $urandom_range(0, 14);
    endfunction

    // Offers a request, waits until it is taken and, if predicted, records what it should produce.
    task automatic send_request(input logic [7:0] c, input logic eos, input bit predicted);
        int gap;
        int k;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        lex_step(c, eos);
        sent++;
        if (eos) sources++;
        if (predicted) begin
            for (k = 0; k < step_n; k++) tok_q.push_back(step_out[k]);
        end
    endtask

    // Holds the input idle until every predicted token has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tok_q.size() != 0) @(posedge aclk);
    endtask

    // One well-formed piece of source with random content, or a noise byte.
    task automatic send_fragment();
        logic [7:0] c;
        int         sel;
        sel   = $urandom_range(0, 11);
        case (sel)
            0: begin
                case ($urandom_range(0, 2))
                    0:       c = CH_SPACE;
                    1:       c = CH_TAB;
                    default: c = CH_CR;
                endcase
                send_request(c, 1'b0, 1'b1);
            end
            1: send_request(CH_LF, 1'b0, 1'b1);
            2, 11: begin
                case ($urandom_range(0, 9))
                    0:       c = CH_LPAREN;
                    1:       c = CH_RPAREN;
                    2:       c = CH_LBRACE;
                    3:       c = CH_RBRACE;
                    4:       c = CH_SEMI;
                    5:       c = CH_COMMA;
                    6:       c = CH_DOT;
                    7:       c = CH_MINUS;
                    8:       c = CH_PLUS;
                    default: c = CH_STAR;
                endcase
                send_request(c, 1'b0, 1'b1);
            end
            3: begin
                case ($urandom_range(0, 3))
                    0:       c = CH_BANG;
                    1:       c = CH_EQ;
                    2:       c = CH_LT;
                    default: c = CH_GT;
                endcase
                send_request(c, 1'b0, 1'b1);
                if ($urandom_range(0, 1) == 1) send_request(CH_EQ, 1'b0, 1'b1);
            end
            4: send_request(CH_SLASH, 1'b0, 1'b1);
            5, 6: begin
                repeat ($urandom_range(1, 4)) send_request(CH_0 + 8'($urandom_range(0, 9)),
                                                           1'b0, 1'b1);
                case ($urandom_range(0, 2))
                    1: begin
                        send_request(CH_DOT, 1'b0, 1'b1);
                        repeat ($urandom_range(1, 3))
                            send_request(CH_0 + 8'($urandom_range(0, 9)), 1'b0, 1'b1);
                    end
                    // A trailing dot gives a number and a dot token, unless a digit follows.
                    2: send_request(CH_DOT, 1'b0, 1'b1);
                    default: ;
                endcase
            end
            7: begin
                send_request(CH_QUOTE, 1'b0, 1'b1);
                repeat ($urandom_range(0, 6)) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CH_QUOTE || $urandom_range(0, 5) == 0) c = CH_LF;
                    send_request(c, 1'b0, 1'b1);
                end
                // Now and then the string stays open and runs on.
                if ($urandom_range(0, 7) != 0) send_request(CH_QUOTE, 1'b0, 1'b1);
            end
            8: begin
                send_request(CH_SLASH, 1'b0, 1'b1);
                send_request(CH_SLASH, 1'b0, 1'b1);
                repeat ($urandom_range(0, 8)) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CH_LF) c = CH_SPACE;
                    send_request(c, 1'b0, 1'b1);
                end
                send_request(CH_LF, 1'b0, 1'b1);
            end
            default: send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        endcase
    endtask

    // Result side: random stalls, every accepted token checked against the oldest prediction.
    initial begin : result_sink
        int         stall;
        token_rec_t got;
        token_rec_t want;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = '{m_tdata[4:0], m_tdata[20:5], m_tdata[36:21], m_tdata[52:37], m_tlast};
            if (tok_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("stray token: kind %0d start %0d len %0d line %0d last %0b",
                             got.kind, got.start, got.len, got.line, got.last);
            end else begin
                want = tok_q.pop_front();
                checked++;
                if (got !== want || m_tdata[55:53] !== 3'b000) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("token %0d mismatch: expected kind %0d start %0d len %0d line %0d last %0b",
                                 checked, want.kind, want.start, want.len, want.line, want.last);
                        $display("    got kind %0d start %0d len %0d line %0d last %0b pad %0h",
                                 got.kind, got.start, got.len, got.line, got.last,
                                 m_tdata[55:53]);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles with %0d tokens outstanding", cycles, tok_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int       i;
        dir_row_t row;
        lex_reset();
        dir_rows = '{
            '{CH_LPAREN,    1'b0, 1'b1, KIND_LPAREN,     16'd0, 16'd1, 16'd1},
            '{8'h00,        1'b0, 1'b1, KIND_UNEXPECTED, 16'd1, 16'd1, 16'd1},
            '{8'hFF,        1'b0, 1'b1, KIND_UNEXPECTED, 16'd2, 16'd1, 16'd1},
            '{CH_LF,        1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_0,         1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_9,         1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_DOT,       1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_SEMI,      1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_QUOTE,     1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_LF,        1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_QUOTE,     1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_BANG,      1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_EQ,        1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_SLASH,     1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_SLASH,     1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{8'h80,        1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_LF,        1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_LT,        1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{8'h00,        1'b1, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_QUOTE,     1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_LOWER_A,   1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{8'hFF,        1'b1, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{8'h5A,        1'b1, 1'b1, KIND_EOF,        16'd0, 16'd0, 16'd1},
            '{CH_0 + 8'd7,  1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{CH_DOT,       1'b0, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0},
            '{8'hA5,        1'b1, 1'b0, 5'd0, 16'd0, 16'd0, 16'd0}
        };
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed sources: error bytes, a number cut by a dot, a string over a line break,
        // a comment, a held operator at end, an open string, an empty source and a number with a trailing dot.
        for (i = 0; i < $size(dir_rows); i++) begin
            row = dir_rows[i];
            send_request(row.ch, row.eos, !row.typed);
            if (row.typed) tok_q.push_back('{row.kind, row.start, row.len, row.line, 1'b1});
        end

        // Random sources of mostly well-formed pieces, each closed by an end request.
        while (sent < RANDOM_ITEMS) begin
            repeat ($urandom_range(0, 12)) send_fragment();
            send_request(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            if (sources % 20 == 7) drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Lexed %0d requests in %0d sources with random stalls on both sides.",
                 sent, sources);
        $display("%0d tokens checked, %0d mismatches, %0d tokens missing.",
                 checked, mismatches, tok_q.size());
        if (mismatches == 0 && tok_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- source_char_lexer.f -----
+incdir+design
design/scl_pkg.sv
design/scl_front.sv
design/scl_queue.sv
design/scl_back.sv
design/source_char_lexer.sv
bench/tb.sv
